/* hdl/tsrm_pkg.sv */
// Shared types and constants for the two-way sorted run merge.
// No dependencies.
package tsrm_pkg;

  localparam int VALUE_W     = 32;
  localparam int RES_CNT_W   = 5;
  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 5'd16;

  typedef enum logic [1:0] {
    KIND_A_ELEM = 2'd0,
    KIND_B_ELEM = 2'd1,
    KIND_A_END  = 2'd2,
    KIND_B_END  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_ELEM = 2'd0,
    ST_CMPL = 2'd1,
    ST_DROP = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_MERGE,
    S_CMPL
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rewind;
  } buf_ctl_t;

  typedef struct packed {
    logic has;
    logic full;
    logic one;
  } buf_sts_t;

endpackage

/* hdl/tsrm_buf.sv */
// One run buffer: circular store in a synchronous memory with head and count.
// Head word is prefetched every cycle, with write-to-read forwarding.
// Depends on tsrm_pkg.
module tsrm_buf #(
  parameter int BUF_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsrm_pkg::buf_ctl_t                  ctl,
  input  logic signed [tsrm_pkg::VALUE_W-1:0] wdata,
  output logic signed [tsrm_pkg::VALUE_W-1:0] head_data,
  output tsrm_pkg::buf_sts_t                  sts
);

  localparam int IDX_W = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int CNT_W = $clog2(BUF_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [tsrm_pkg::VALUE_W-1:0] mem_r [BUF_DEPTH];
  logic signed [tsrm_pkg::VALUE_W-1:0] rdata_r;
  logic [IDX_W-1:0] head_r, head_nxt, head_inc, waddr, raddr;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [SUM_W-1:0] wsum;

  always_comb begin
    wsum     = SUM_W'(head_r) + SUM_W'(cnt_r);
    waddr    = (wsum >= SUM_W'(BUF_DEPTH)) ? IDX_W'(wsum - SUM_W'(BUF_DEPTH)) : IDX_W'(wsum);
    head_inc = (head_r == IDX_W'(BUF_DEPTH - 1)) ? '0 : head_r + 1'b1;
    if (ctl.rewind) begin
      head_nxt = '0;
    end else if (ctl.pop) begin
      head_nxt = head_inc;
    end else begin
      head_nxt = head_r;
    end
    cnt_nxt = cnt_r;
    if (ctl.push) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (ctl.pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
    raddr = head_nxt;
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[waddr] <= wdata;
    end
    if (ctl.push && (waddr == raddr)) begin
      rdata_r <= wdata;
    end else begin
      rdata_r <= mem_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  assign head_data = rdata_r;
  assign sts.has   = (cnt_r != '0);
  assign sts.full  = (cnt_r == CNT_W'(BUF_DEPTH));
  assign sts.one   = (cnt_r == CNT_W'(1));

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> sts.has) else $error("pop from empty run buffer");
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.push |-> !sts.full) else $error("push into full run buffer");
  a_no_push_pop: assert property (@(posedge clk) disable iff (!rst_n)
    !(ctl.push && ctl.pop)) else $error("push and pop in one cycle");

endmodule

/* hdl/two_way_sorted_run_merge.sv */
// Two-way merge of ascending signed runs; top level with the merge sequencer.
// Depends on tsrm_pkg and tsrm_buf.
//
// Each accepted item is taken in first (an element is written to its run's
// buffer memory then, unless that run has ended or its buffer is full), then
// the merger emits the results it causes (a drop report, merged elements up
// to 16 results in all, or a completion item), and closes once it finds
// nothing more to emit. The heads of both runs are prefetched every cycle
// from the two registered-read buffer memories, so merged elements leave
// back to back while the result side keeps up. The next item is taken only
// after the current one is finished; a result may still be waiting in the
// output register at that point. Output stalls hold the merger back.
module two_way_sorted_run_merge #(
  parameter int BUF_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_kind,
  input  logic signed [tsrm_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [tsrm_pkg::VALUE_W-1:0] out_merged_value,
  output logic [1:0]                          out_status,
  output logic                                out_last
);

  tsrm_pkg::state_t state_r, state_nxt;
  logic a_ended_r, a_ended_nxt, b_ended_r, b_ended_nxt;
  logic [tsrm_pkg::RES_CNT_W-1:0] res_cnt_r, res_cnt_nxt;
  logic elem_seen_r, elem_seen_nxt;
  logic signed [tsrm_pkg::VALUE_W-1:0] drop_value_r, drop_value_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [tsrm_pkg::VALUE_W-1:0] out_value_r, out_value_nxt;
  tsrm_pkg::status_t out_status_r, out_status_nxt;
  logic out_last_r, out_last_nxt;

  tsrm_pkg::buf_ctl_t a_ctl, b_ctl;
  tsrm_pkg::buf_sts_t a_sts, b_sts;
  logic signed [tsrm_pkg::VALUE_W-1:0] a_data, b_data;

  logic out_free, both_ended, cand, take_a, pop_last, drained, load_out;
  logic signed [tsrm_pkg::VALUE_W-1:0] ld_value;
  tsrm_pkg::status_t ld_status;
  logic ld_last;

  tsrm_buf #(.BUF_DEPTH(BUF_DEPTH)) u_buf_a (
    .clk(clk), .rst_n(rst_n), .ctl(a_ctl), .wdata(in_value),
    .head_data(a_data), .sts(a_sts)
  );

  tsrm_buf #(.BUF_DEPTH(BUF_DEPTH)) u_buf_b (
    .clk(clk), .rst_n(rst_n), .ctl(b_ctl), .wdata(in_value),
    .head_data(b_data), .sts(b_sts)
  );

  always_comb begin
    out_free   = !out_valid_r || out_ready;
    both_ended = a_ended_r && b_ended_r;
    cand       = (a_sts.has && b_sts.has) || (a_sts.has && b_ended_r) ||
                 (b_sts.has && a_ended_r);
    take_a     = (a_sts.has && b_sts.has) ? (a_data < b_data) : a_sts.has;
    pop_last   = both_ended && (take_a ? (a_sts.one && !b_sts.has)
                                       : (b_sts.one && !a_sts.has));
    drained    = both_ended && !a_sts.has && !b_sts.has;

    state_nxt      = state_r;
    a_ended_nxt    = a_ended_r;
    b_ended_nxt    = b_ended_r;
    res_cnt_nxt    = res_cnt_r;
    elem_seen_nxt  = elem_seen_r;
    drop_value_nxt = drop_value_r;
    a_ctl          = '0;
    b_ctl          = '0;
    in_ready       = 1'b0;
    load_out       = 1'b0;
    ld_value       = '0;
    ld_status      = tsrm_pkg::ST_ELEM;
    ld_last        = 1'b0;

    case (state_r)
      tsrm_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          res_cnt_nxt    = '0;
          elem_seen_nxt  = 1'b0;
          drop_value_nxt = in_value;
          state_nxt      = tsrm_pkg::S_MERGE;
          case (tsrm_pkg::kind_t'(in_kind))
            tsrm_pkg::KIND_A_ELEM: begin
              if (a_ended_r || a_sts.full) begin
                state_nxt = tsrm_pkg::S_DROP;
              end else begin
                a_ctl.push = 1'b1;
              end
            end
            tsrm_pkg::KIND_B_ELEM: begin
              if (b_ended_r || b_sts.full) begin
                state_nxt = tsrm_pkg::S_DROP;
              end else begin
                b_ctl.push = 1'b1;
              end
            end
            tsrm_pkg::KIND_A_END: a_ended_nxt = 1'b1;
            tsrm_pkg::KIND_B_END: b_ended_nxt = 1'b1;
            default: ;
          endcase
        end
      end
      tsrm_pkg::S_DROP: begin
        if (out_free) begin
          load_out    = 1'b1;
          ld_value    = drop_value_r;
          ld_status   = tsrm_pkg::ST_DROP;
          res_cnt_nxt = res_cnt_r + 1'b1;
          state_nxt   = tsrm_pkg::S_MERGE;
        end
      end
      tsrm_pkg::S_MERGE: begin
        if (cand && (res_cnt_r != tsrm_pkg::MAX_RESULTS)) begin
          if (out_free) begin
            load_out      = 1'b1;
            ld_value      = take_a ? a_data : b_data;
            ld_last       = pop_last;
            a_ctl.pop     = take_a;
            b_ctl.pop     = !take_a;
            res_cnt_nxt   = res_cnt_r + 1'b1;
            elem_seen_nxt = 1'b1;
          end
        end else if (drained && !elem_seen_r) begin
          state_nxt = tsrm_pkg::S_CMPL;
        end else begin
          if (drained) begin
            a_ended_nxt  = 1'b0;
            b_ended_nxt  = 1'b0;
            a_ctl.rewind = 1'b1;
            b_ctl.rewind = 1'b1;
          end
          state_nxt = tsrm_pkg::S_IDLE;
        end
      end
      tsrm_pkg::S_CMPL: begin
        if (out_free) begin
          load_out     = 1'b1;
          ld_status    = tsrm_pkg::ST_CMPL;
          ld_last      = 1'b1;
          a_ended_nxt  = 1'b0;
          b_ended_nxt  = 1'b0;
          a_ctl.rewind = 1'b1;
          b_ctl.rewind = 1'b1;
          state_nxt    = tsrm_pkg::S_IDLE;
        end
      end
      default: state_nxt = tsrm_pkg::S_IDLE;
    endcase

    out_valid_nxt  = load_out || (out_valid_r && !out_ready);
    out_value_nxt  = load_out ? ld_value  : out_value_r;
    out_status_nxt = load_out ? ld_status : out_status_r;
    out_last_nxt   = load_out ? ld_last   : out_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsrm_pkg::S_IDLE;
      a_ended_r   <= 1'b0;
      b_ended_r   <= 1'b0;
      res_cnt_r   <= '0;
      elem_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_ended_r   <= a_ended_nxt;
      b_ended_r   <= b_ended_nxt;
      res_cnt_r   <= res_cnt_nxt;
      elem_seen_r <= elem_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    drop_value_r <= drop_value_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_merged_value = out_value_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_cnt_r <= tsrm_pkg::MAX_RESULTS) else $error("too many results in one step");
  a_cmpl_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == tsrm_pkg::ST_CMPL)) |-> out_last_r)
    else $error("completion item without last");
  a_drop_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == tsrm_pkg::ST_DROP)) |-> !out_last_r)
    else $error("drop report marked last");
  a_cmpl_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == tsrm_pkg::S_CMPL) && out_free) |=> (!a_ended_r && !b_ended_r))
    else $error("run end flags survive completion");

endmodule
